[rtl/core/phem_pkg.sv]
// Shared types and constants for the path health EMA monitor.
`timescale 1ns / 1ps
`default_nettype none

package phem_pkg;

    // Path table
    localparam int NUM_PATHS = 16;
    localparam int PATH_W    = 4;

    // Field widths
    localparam int W_W     = 10;   // smoothing weight
    localparam int CNT_W   = 16;   // period counters
    localparam int RTO_W   = 17;   // timeout in ms
    localparam int LIM_W   = 20;   // rate limits
    localparam int IDLE_W  = 8;    // idle counter and limit
    localparam int PROD_W  = 36;   // EMA product
    localparam int VOL_W   = 26;   // EMA volume
    localparam int RATE_W  = 36;   // EMA rate
    localparam int AP_W    = 46;   // value * 1000000
    localparam int ACC_W   = 47;   // blended sum before the divide by 1000
    localparam int REM_W   = 10;   // remainder of the divide by 1000

    // Scale factors
    localparam logic [19:0]    VAL_SCALE  = 20'd1000000;
    localparam logic [W_W-1:0] VOL_SCALE  = 10'd1000;
    localparam logic [W_W-1:0] WEIGHT_DIV = 10'd1000;

    // Stream and config port widths
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 20;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHT     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOSS_LIM   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RETRANS_LIM = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RTO_LIM    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_LIM   = 3'd4;

    // Outcome of one EMA update
    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_UP,
        UPD_DOWN
    } upd_t;

    // Alarm codes, in priority order
    typedef enum logic [1:0] {
        ALARM_NONE,
        ALARM_LOSS,
        ALARM_RETRANS,
        ALARM_RTO
    } alarm_t;

    // Status from an EMA unit to the controller
    typedef struct packed {
        logic done;
        upd_t upd;
    } vema_status_t;

endpackage

`default_nettype wire

[rtl/core/phem_vema.sv]
// Bit-serial volume-weighted EMA update unit: shift-add blend, divide by 1000, rate divide.
`timescale 1ns / 1ps
`default_nettype none

module phem_vema (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [phem_pkg::W_W-1:0]        weight,
    input  logic [phem_pkg::W_W-1:0]        weight_c,
    input  logic [phem_pkg::CNT_W-1:0]      value,
    input  logic [phem_pkg::CNT_W-1:0]      vol,
    input  logic [phem_pkg::PROD_W-1:0]     prod_old,
    input  logic [phem_pkg::VOL_W-1:0]      vol_old,
    input  logic [phem_pkg::RATE_W-1:0]     rate_old,
    output phem_pkg::vema_status_t          status,
    output logic [phem_pkg::PROD_W-1:0]     product,
    output logic [phem_pkg::VOL_W-1:0]      volume,
    output logic [phem_pkg::RATE_W-1:0]     rate
);

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(phem_pkg::W_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(phem_pkg::ACC_W - 1);
    localparam logic [STEP_W-1:0] RATE_LAST = STEP_W'(phem_pkg::PROD_W - 1);

    typedef enum logic [2:0] {
        V_IDLE,
        V_MUL,
        V_DIV,
        V_RATE,
        V_FIN
    } vstate_t;

    vstate_t                       state_reg, state_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic                          done_reg, done_next;

    // Operands
    logic                          zero_vol_reg;
    logic [phem_pkg::W_W-1:0]      wt_reg, wtc_reg;
    logic [phem_pkg::AP_W-1:0]     ap_reg;
    logic [phem_pkg::VOL_W-1:0]    av_reg;
    logic [phem_pkg::PROD_W-1:0]   bp_reg;
    logic [phem_pkg::VOL_W-1:0]    bv_reg;
    logic [phem_pkg::RATE_W-1:0]   rold_reg;

    // Working registers
    logic [phem_pkg::ACC_W-1:0]    accp_reg, accv_reg;
    logic [phem_pkg::REM_W-1:0]    remp_reg, remv_reg;
    logic [phem_pkg::RATE_W-1:0]   rq_reg;
    logic [phem_pkg::VOL_W-1:0]    rrem_reg;

    // Results
    logic [phem_pkg::PROD_W-1:0]   res_prod_reg;
    logic [phem_pkg::VOL_W-1:0]    res_vol_reg;
    logic [phem_pkg::RATE_W-1:0]   res_rate_reg;
    phem_pkg::upd_t                res_upd_reg;

    // Shift-add step, weight bits taken MSB first
    logic [phem_pkg::ACC_W-1:0]    mulp_next, mulv_next;
    always_comb begin
        mulp_next = {accp_reg[phem_pkg::ACC_W-2:0], 1'b0}
                  + (wt_reg[phem_pkg::W_W-1]  ? phem_pkg::ACC_W'(ap_reg) : '0)
                  + (wtc_reg[phem_pkg::W_W-1] ? phem_pkg::ACC_W'(bp_reg) : '0);
        mulv_next = {accv_reg[phem_pkg::ACC_W-2:0], 1'b0}
                  + (wt_reg[phem_pkg::W_W-1]  ? phem_pkg::ACC_W'(av_reg) : '0)
                  + (wtc_reg[phem_pkg::W_W-1] ? phem_pkg::ACC_W'(bv_reg) : '0);
    end

    // Restoring divide by 1000, one quotient bit per cycle
    logic [phem_pkg::REM_W:0]      trial_p, trial_v;
    logic                          ge_p, ge_v;
    logic [phem_pkg::REM_W:0]      diff_p, diff_v;
    always_comb begin
        trial_p = {remp_reg, accp_reg[phem_pkg::ACC_W-1]};
        trial_v = {remv_reg, accv_reg[phem_pkg::ACC_W-1]};
        ge_p    = trial_p >= {1'b0, phem_pkg::WEIGHT_DIV};
        ge_v    = trial_v >= {1'b0, phem_pkg::WEIGHT_DIV};
        diff_p  = trial_p - {1'b0, phem_pkg::WEIGHT_DIV};
        diff_v  = trial_v - {1'b0, phem_pkg::WEIGHT_DIV};
    end

    // Restoring rate divide, product over volume
    logic [phem_pkg::VOL_W:0]      trial_r, diff_r;
    logic                          ge_r;
    always_comb begin
        trial_r = {rrem_reg, rq_reg[phem_pkg::RATE_W-1]};
        ge_r    = trial_r >= {1'b0, accv_reg[phem_pkg::VOL_W-1:0]};
        diff_r  = trial_r - {1'b0, accv_reg[phem_pkg::VOL_W-1:0]};
    end

    // Final rate, zero when the new volume is zero
    logic [phem_pkg::RATE_W-1:0]   rate_new;
    always_comb begin
        rate_new = (accv_reg[phem_pkg::VOL_W-1:0] == '0) ? '0 : rq_reg;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            V_IDLE: begin
                if (start) begin
                    state_next = V_MUL;
                    step_next  = '0;
                end
            end
            V_MUL: begin
                step_next = step_reg + 1'b1;
                if (step_reg == MUL_LAST) begin
                    state_next = V_DIV;
                    step_next  = '0;
                end
            end
            V_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST) begin
                    state_next = V_RATE;
                    step_next  = '0;
                end
            end
            V_RATE: begin
                step_next = step_reg + 1'b1;
                if (step_reg == RATE_LAST) begin
                    state_next = V_FIN;
                    step_next  = '0;
                end
            end
            V_FIN: begin
                state_next = V_IDLE;
                done_next  = 1'b1;
            end
            default: begin
                state_next = V_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= V_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            V_IDLE: begin
                if (start) begin
                    zero_vol_reg <= (vol == '0);
                    wt_reg       <= weight;
                    wtc_reg      <= weight_c;
                    ap_reg       <= phem_pkg::AP_W'(value) * phem_pkg::AP_W'(phem_pkg::VAL_SCALE);
                    av_reg       <= phem_pkg::VOL_W'(vol) * phem_pkg::VOL_W'(phem_pkg::VOL_SCALE);
                    bp_reg       <= prod_old;
                    bv_reg       <= vol_old;
                    rold_reg     <= rate_old;
                    accp_reg     <= '0;
                    accv_reg     <= '0;
                end
            end
            V_MUL: begin
                accp_reg <= mulp_next;
                accv_reg <= mulv_next;
                wt_reg   <= {wt_reg[phem_pkg::W_W-2:0], 1'b0};
                wtc_reg  <= {wtc_reg[phem_pkg::W_W-2:0], 1'b0};
                remp_reg <= '0;
                remv_reg <= '0;
            end
            V_DIV: begin
                accp_reg <= {accp_reg[phem_pkg::ACC_W-2:0], ge_p};
                accv_reg <= {accv_reg[phem_pkg::ACC_W-2:0], ge_v};
                remp_reg <= ge_p ? diff_p[phem_pkg::REM_W-1:0] : trial_p[phem_pkg::REM_W-1:0];
                remv_reg <= ge_v ? diff_v[phem_pkg::REM_W-1:0] : trial_v[phem_pkg::REM_W-1:0];
                // product is the low 36 bits of the quotient
                rq_reg   <= {accp_reg[phem_pkg::RATE_W-2:0], ge_p};
                rrem_reg <= '0;
            end
            V_RATE: begin
                rq_reg   <= {rq_reg[phem_pkg::RATE_W-2:0], ge_r};
                rrem_reg <= ge_r ? diff_r[phem_pkg::VOL_W-1:0] : trial_r[phem_pkg::VOL_W-1:0];
            end
            V_FIN: begin
                if (zero_vol_reg) begin
                    res_prod_reg <= bp_reg;
                    res_vol_reg  <= bv_reg;
                    res_rate_reg <= rold_reg;
                    res_upd_reg  <= phem_pkg::UPD_NONE;
                end else begin
                    res_prod_reg <= accp_reg[phem_pkg::PROD_W-1:0];
                    res_vol_reg  <= accv_reg[phem_pkg::VOL_W-1:0];
                    res_rate_reg <= rate_new;
                    res_upd_reg  <= (rate_new > rold_reg) ? phem_pkg::UPD_UP
                                                          : phem_pkg::UPD_DOWN;
                end
            end
            default: begin
            end
        endcase
    end

    assign status.done = done_reg;
    assign status.upd  = res_upd_reg;
    assign product     = res_prod_reg;
    assign volume      = res_vol_reg;
    assign rate        = res_rate_reg;

endmodule

`default_nettype wire

[rtl/core/path_health_ema_monitor_unit.sv]
// Top level of the path health EMA monitor: path table, alarms, idle tracking, stream ports.
//
// Usage:
//   s_ channel: one transaction per timer period for one path, carrying that
//   period's loss, retransmit and timeout counters. m_ channel: one result
//   transaction per input, carrying the alarm code, first-failure and
//   keepalive flags and the smoothed loss and retransmit rates.
//   The cfg_ port writes the smoothing weight and the limits; write it only
//   while no transaction is in flight.
//   Each item runs through two bit-serial EMA units side by side: shift-add
//   blending, divide by 1000 and rate divide, one bit per cycle. m_tvalid
//   rises once the units finish and the output register is free, and only
//   then can the next input be accepted, so the block does not take a new
//   item while the units are busy with the last one.
//   The result sits in an output register; a new input is taken while it
//   waits. If the receiver stalls past the next item's completion, that item
//   waits in the units and s_tready stays low until the register frees up.
//   Reset (aresetn low, synchronous) restores the register defaults and
//   marks every path entry as empty, which reads as all zero state.
`timescale 1ns / 1ps
`default_nettype none

module path_health_ema_monitor_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // path[3:0], lost_count[19:4], outstanding_count[35:20], retrans_count[51:36],
    // sent_count[67:52], received_flag[68], max_rto_ms[85:69], zero[87:86]
    input  logic [phem_pkg::IN_TDATA_W-1:0]       s_tdata,
    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // path_out[3:0], alarm[5:4], mark_failed[6], keepalive_request[7],
    // loss_rate_out[43:8], retrans_rate_out[79:44]
    output logic [phem_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // Configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [phem_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [phem_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    // Configuration registers
    logic [phem_pkg::W_W-1:0]     weight_reg;
    logic [phem_pkg::LIM_W-1:0]   loss_lim_reg;
    logic [phem_pkg::LIM_W-1:0]   retrans_lim_reg;
    logic [phem_pkg::RTO_W-1:0]   rto_lim_reg;
    logic [phem_pkg::IDLE_W-1:0]  idle_lim_reg;

    // Control
    state_t                        state_reg, state_next;
    logic                          m_valid_reg, m_valid_next;
    logic [phem_pkg::NUM_PATHS-1:0] path_vld_reg;

    // Path table
    logic [phem_pkg::PROD_W-1:0]  lprod_reg [phem_pkg::NUM_PATHS];
    logic [phem_pkg::VOL_W-1:0]   lvol_reg  [phem_pkg::NUM_PATHS];
    logic [phem_pkg::RATE_W-1:0]  lrate_reg [phem_pkg::NUM_PATHS];
    logic [phem_pkg::PROD_W-1:0]  rprod_reg [phem_pkg::NUM_PATHS];
    logic [phem_pkg::VOL_W-1:0]   rvol_reg  [phem_pkg::NUM_PATHS];
    logic [phem_pkg::RATE_W-1:0]  rrate_reg [phem_pkg::NUM_PATHS];
    logic                          bad_reg   [phem_pkg::NUM_PATHS];
    logic [phem_pkg::IDLE_W-1:0]  idle_reg  [phem_pkg::NUM_PATHS];

    // Latched input fields
    logic [phem_pkg::PATH_W-1:0]  path_reg;
    logic                          rcv_reg;
    logic [phem_pkg::RTO_W-1:0]   rto_reg;

    // Output payload
    logic [phem_pkg::PATH_W-1:0]  out_path_reg;
    phem_pkg::alarm_t              out_alarm_reg;
    logic                          out_failed_reg;
    logic                          out_keep_reg;
    logic [phem_pkg::RATE_W-1:0]  out_lrate_reg;
    logic [phem_pkg::RATE_W-1:0]  out_rrate_reg;

    // Input field unpacking
    logic [phem_pkg::PATH_W-1:0]  s_path;
    logic [phem_pkg::CNT_W-1:0]   s_lost, s_outst, s_retr, s_sent;
    logic                          s_rcv;
    logic [phem_pkg::RTO_W-1:0]   s_rto;
    assign s_path  = s_tdata[3:0];
    assign s_lost  = s_tdata[19:4];
    assign s_outst = s_tdata[35:20];
    assign s_retr  = s_tdata[51:36];
    assign s_sent  = s_tdata[67:52];
    assign s_rcv   = s_tdata[68];
    assign s_rto   = s_tdata[85:69];

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Effective weight: zero acts as one, above 1000 acts as 1000
    logic [phem_pkg::W_W-1:0] w_eff, w_comp;
    always_comb begin
        if (weight_reg == '0) begin
            w_eff = phem_pkg::W_W'(1);
        end else if (weight_reg > phem_pkg::WEIGHT_DIV) begin
            w_eff = phem_pkg::WEIGHT_DIV;
        end else begin
            w_eff = weight_reg;
        end
        w_comp = phem_pkg::WEIGHT_DIV - w_eff;
    end

    // Old EMA state of the arriving path; empty entries read as zero
    logic                          s_vld;
    logic [phem_pkg::PROD_W-1:0]  lprod_rd, rprod_rd;
    logic [phem_pkg::VOL_W-1:0]   lvol_rd, rvol_rd;
    logic [phem_pkg::RATE_W-1:0]  lrate_rd, rrate_rd;
    always_comb begin
        s_vld    = path_vld_reg[s_path];
        lprod_rd = s_vld ? lprod_reg[s_path] : '0;
        lvol_rd  = s_vld ? lvol_reg[s_path]  : '0;
        lrate_rd = s_vld ? lrate_reg[s_path] : '0;
        rprod_rd = s_vld ? rprod_reg[s_path] : '0;
        rvol_rd  = s_vld ? rvol_reg[s_path]  : '0;
        rrate_rd = s_vld ? rrate_reg[s_path] : '0;
    end

    // EMA units
    phem_pkg::vema_status_t        loss_st, retr_st;
    logic [phem_pkg::PROD_W-1:0]  loss_prod, retr_prod;
    logic [phem_pkg::VOL_W-1:0]   loss_vol, retr_vol;
    logic [phem_pkg::RATE_W-1:0]  loss_rate, retr_rate;

    phem_vema u_loss (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .weight   (w_eff),
        .weight_c (w_comp),
        .value    (s_lost),
        .vol      (s_outst),
        .prod_old (lprod_rd),
        .vol_old  (lvol_rd),
        .rate_old (lrate_rd),
        .status   (loss_st),
        .product  (loss_prod),
        .volume   (loss_vol),
        .rate     (loss_rate)
    );

    phem_vema u_retr (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .weight   (w_eff),
        .weight_c (w_comp),
        .value    (s_retr),
        .vol      (s_sent),
        .prod_old (rprod_rd),
        .vol_old  (rvol_rd),
        .rate_old (rrate_rd),
        .status   (retr_st),
        .product  (retr_prod),
        .volume   (retr_vol),
        .rate     (retr_rate)
    );

    // Alarm decision and idle tracking for the finished item
    logic                          p_vld, bad_old;
    logic [phem_pkg::IDLE_W-1:0]  idle_old, idle_new;
    logic                          loss_hit, retr_hit, rto_hit;
    phem_pkg::alarm_t              alarm;
    logic                          failed, keep;
    always_comb begin
        p_vld    = path_vld_reg[path_reg];
        bad_old  = p_vld ? bad_reg[path_reg]  : 1'b0;
        idle_old = p_vld ? idle_reg[path_reg] : '0;

        loss_hit = (loss_lim_reg != '0) && (loss_st.upd == phem_pkg::UPD_UP)
                && (loss_rate >= phem_pkg::RATE_W'(loss_lim_reg));
        retr_hit = (retrans_lim_reg != '0) && (retr_st.upd == phem_pkg::UPD_UP)
                && (retr_rate >= phem_pkg::RATE_W'(retrans_lim_reg));
        rto_hit  = (rto_lim_reg != '0) && (rto_reg >= rto_lim_reg);

        if (loss_hit) begin
            alarm = phem_pkg::ALARM_LOSS;
        end else if (retr_hit) begin
            alarm = phem_pkg::ALARM_RETRANS;
        end else if (rto_hit) begin
            alarm = phem_pkg::ALARM_RTO;
        end else begin
            alarm = phem_pkg::ALARM_NONE;
        end
        failed = (loss_hit || retr_hit) && !bad_old;

        // saturating idle counter
        if ((idle_lim_reg != '0) && (loss_st.upd == phem_pkg::UPD_NONE)
                && (retr_st.upd == phem_pkg::UPD_NONE) && !rcv_reg) begin
            idle_new = (idle_old == '1) ? idle_old : idle_old + 1'b1;
            keep     = idle_new >= idle_lim_reg;
        end else begin
            idle_new = '0;
            keep     = 1'b0;
        end
    end

    // Completion: result ready and output register free
    logic out_free, finish;
    assign out_free = !m_valid_reg || m_tready;
    assign finish   = ((state_reg == S_RUN && loss_st.done) || state_reg == S_HOLD) && out_free;

    // Controller
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (loss_st.done) begin
                    state_next = finish ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (finish) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (finish) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            path_vld_reg    <= '0;
            weight_reg      <= 10'd500;
            loss_lim_reg    <= 20'd250;
            retrans_lim_reg <= 20'd500;
            rto_lim_reg     <= 17'd1500;
            idle_lim_reg    <= 8'd0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (finish) begin
                path_vld_reg[path_reg] <= 1'b1;
            end
            // register writes
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    phem_pkg::CFG_WEIGHT:      weight_reg      <= cfg_wr_data[phem_pkg::W_W-1:0];
                    phem_pkg::CFG_LOSS_LIM:    loss_lim_reg    <= cfg_wr_data;
                    phem_pkg::CFG_RETRANS_LIM: retrans_lim_reg <= cfg_wr_data;
                    phem_pkg::CFG_RTO_LIM:     rto_lim_reg     <= cfg_wr_data[phem_pkg::RTO_W-1:0];
                    phem_pkg::CFG_IDLE_LIM:    idle_lim_reg    <= cfg_wr_data[phem_pkg::IDLE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload: input latch, path table write-back, output register
    always_ff @(posedge aclk) begin
        if (accept) begin
            path_reg <= s_path;
            rcv_reg  <= s_rcv;
            rto_reg  <= s_rto;
        end
        if (finish) begin
            lprod_reg[path_reg] <= loss_prod;
            lvol_reg[path_reg]  <= loss_vol;
            lrate_reg[path_reg] <= loss_rate;
            rprod_reg[path_reg] <= retr_prod;
            rvol_reg[path_reg]  <= retr_vol;
            rrate_reg[path_reg] <= retr_rate;
            bad_reg[path_reg]   <= (alarm != phem_pkg::ALARM_NONE);
            idle_reg[path_reg]  <= idle_new;

            out_path_reg   <= path_reg;
            out_alarm_reg  <= alarm;
            out_failed_reg <= failed;
            out_keep_reg   <= keep;
            out_lrate_reg  <= loss_rate;
            out_rrate_reg  <= retr_rate;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_rrate_reg, out_lrate_reg, out_keep_reg, out_failed_reg,
                       out_alarm_reg, out_path_reg};

    // Both EMA units run in lockstep
    a_units_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        loss_st.done == retr_st.done)
        else $error("EMA units out of step");

    // A unit finishes only while the controller waits for it
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        loss_st.done |-> state_reg == S_RUN)
        else $error("EMA result arrived outside of a run");

    // First failure only comes with a loss or retransmit alarm
    a_failed_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_failed_reg) |->
            (out_alarm_reg == phem_pkg::ALARM_LOSS || out_alarm_reg == phem_pkg::ALARM_RETRANS))
        else $error("mark_failed without loss or retransmit alarm");

    // Keepalive needs an idle period, which rules out rate alarms
    a_keep_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_keep_reg) |-> !out_failed_reg)
        else $error("keepalive together with a failure mark");

endmodule

`default_nettype wire
